// ===== rtl/dqra_pkg.sv =====
// Shared types, codes and widths for the deque with random access.
`default_nettype none

package dqra_pkg;

  // Fixed field widths of the request and result items
  localparam int unsigned OP_W     = 3;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LENGTH_W = 9;
  localparam int unsigned STATUS_W = 2;

  // Default configuration
  localparam int unsigned DEF_DEPTH      = 256;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [LENGTH_W-1:0] length_t;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_GET       = 3'd0,
    OP_SET       = 3'd1,
    OP_PUSH_TAIL = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_PUSH_HEAD = 3'd4,
    OP_POP_HEAD  = 3'd5,
    OP_LENGTH    = 3'd6,
    OP_UNUSED    = 3'd7
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the request item
    logic exec;     // run the operation against store and pointers
    logic load;     // move the result into the output register
  } dqra_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dqra_dp.sv =====
// Datapath: request registers, circular element store, pointers and result register.
`default_nettype none

module dqra_dp #(
  parameter int unsigned DEPTH      = dqra_pkg::DEF_DEPTH,
  parameter int unsigned DATA_WIDTH = dqra_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire dqra_pkg::dqra_cmd_t            cmd,
  input  wire logic [dqra_pkg::OP_W-1:0]      in_op,
  input  wire logic [dqra_pkg::INDEX_W-1:0]   in_index,
  input  wire logic [dqra_pkg::VALUE_W-1:0]   in_value,
  output logic      [dqra_pkg::VALUE_W-1:0]   out_read_value,
  output logic      [dqra_pkg::LENGTH_W-1:0]  out_length,
  output logic      [dqra_pkg::STATUS_W-1:0]  out_status
);
  import dqra_pkg::*;

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned XW  = CW + INDEX_W;
  localparam int unsigned SW  = AW + 1;

  typedef logic [AW-1:0]         addr_t;
  typedef logic [CW-1:0]         count_t;
  typedef logic [XW-1:0]         cmp_t;
  typedef logic [SW-1:0]         sum_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  localparam count_t DEPTH_C = count_t'(DEPTH);
  localparam addr_t  LAST_A  = addr_t'(DEPTH - 1);
  localparam sum_t   DEPTH_S = sum_t'(DEPTH);

  // Request registers
  op_t     op_r;
  index_t  idx_r;
  word_t   val_r;

  // Pointer state
  addr_t   head_r, head_nxt;
  count_t  cnt_r, cnt_nxt;

  // Store and its registered read port
  word_t   mem [DEPTH];
  word_t   mem_q_r;
  logic    mem_we, mem_re;
  addr_t   mem_addr;

  // Result bookkeeping between execute and load
  status_t res_status_r, res_status_nxt;
  logic    rd_sel_r, rd_sel_nxt;

  // Output register
  value_t  out_val_r;
  length_t out_len_r;
  status_t out_st_r;

  // Address arithmetic
  logic    idx_oor, empty, full;
  addr_t   logical, slot, head_dec, head_inc;
  sum_t    sum;

  // Latch request item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_op);
      idx_r <= in_index;
      val_r <= word_t'(in_value);
    end
  end

  // Classify and locate the logical slot
  always_comb begin
    idx_oor  = cmp_t'(idx_r) >= cmp_t'(cnt_r);
    empty    = (cnt_r == '0);
    full     = (cnt_r == DEPTH_C);
    head_dec = (head_r == '0) ? LAST_A : head_r - addr_t'(1);
    head_inc = (head_r == LAST_A) ? '0 : head_r + addr_t'(1);

    case (op_r)
      OP_GET, OP_SET: logical = addr_t'(idx_r);
      OP_PUSH_TAIL:   logical = addr_t'(cnt_r);
      OP_POP_TAIL:    logical = addr_t'(cnt_r - count_t'(1));
      default:        logical = '0;
    endcase

    sum  = sum_t'(head_r) + sum_t'(logical);
    slot = (sum >= DEPTH_S) ? addr_t'(sum - DEPTH_S) : addr_t'(sum);
  end

  // Decide the operation's effect
  always_comb begin
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = slot;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = ST_OK;
    rd_sel_nxt     = 1'b0;

    unique case (op_r)
      OP_GET: begin
        if (idx_oor) begin
          res_status_nxt = ST_RANGE;
        end else begin
          mem_re     = 1'b1;
          rd_sel_nxt = 1'b1;
        end
      end
      OP_SET: begin
        if (idx_oor) begin
          res_status_nxt = ST_RANGE;
        end else begin
          mem_we = 1'b1;
        end
      end
      OP_PUSH_TAIL: begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + count_t'(1);
        end
      end
      OP_POP_TAIL: begin
        if (empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          mem_re     = 1'b1;
          rd_sel_nxt = 1'b1;
          cnt_nxt    = cnt_r - count_t'(1);
        end
      end
      OP_PUSH_HEAD: begin
        mem_addr = head_dec;
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          mem_we   = 1'b1;
          head_nxt = head_dec;
          cnt_nxt  = cnt_r + count_t'(1);
        end
      end
      OP_POP_HEAD: begin
        mem_addr = head_r;
        if (empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          mem_re     = 1'b1;
          rd_sel_nxt = 1'b1;
          head_nxt   = head_inc;
          cnt_nxt    = cnt_r - count_t'(1);
        end
      end
      default: begin
        // length report and the unused code change nothing
      end
    endcase
  end

  // Advance pointers on execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold per-item result flags
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      rd_sel_r     <= rd_sel_nxt;
    end
  end

  // Store: one access per execute cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[mem_addr] <= val_r;
    end
    if (cmd.exec && mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // Load output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_val_r <= rd_sel_r ? value_t'(mem_q_r) : '0;
      out_len_r <= length_t'(cnt_r);
      out_st_r  <= res_status_r;
    end
  end

  assign out_read_value = out_val_r;
  assign out_length     = out_len_r;
  assign out_status     = out_st_r;

  // Live count never exceeds capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("live count above capacity");

  // A refused push or pop leaves the count alone
  a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (res_status_nxt == ST_FULL || res_status_nxt == ST_EMPTY))
      |=> $stable(cnt_r) && $stable(head_r))
    else $error("refused operation changed pointers");

  // Store is never written and read in the same cycle
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(mem_we && mem_re))
    else $error("store written and read together");

endmodule

`default_nettype wire

// ===== rtl/dqra_ctrl.sv =====
// Controller: request sequencing state machine and output valid.
`default_nettype none

module dqra_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output dqra_pkg::dqra_cmd_t       cmd
);
  import dqra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output slot can take a result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // Sequence one item: capture, execute, deliver
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Set valid on load, drop it when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // A captured item is executed on the next cycle
  a_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.exec)
    else $error("captured item not executed");

  // A load never overwrites a result still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // A loaded result is presented on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== rtl/deque_with_random_access_unit.sv =====
// Top level of the deque with random access: controller plus datapath.
// Fixed-capacity double-ended queue of DEPTH words held in a circular store
// addressed from a head pointer. Each request item carries one operation (get,
// set, push/pop tail, push/pop head, length) and yields exactly one result item
// with the read word, the live length after the operation and a status code.
// Before its result reaches the output register, an item is captured, then
// executed against the single-port store and the pointers, then loaded with the
// store's registered read data once the output register is free.
// The next item is taken once the result sits in the output register, so a
// stalled output holds further items back only until that register drains.
// No clearing pass follows reset; the block accepts items right away.
`default_nettype none

module deque_with_random_access_unit #(
  parameter int unsigned DEPTH      = dqra_pkg::DEF_DEPTH,
  parameter int unsigned DATA_WIDTH = dqra_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [dqra_pkg::OP_W-1:0]      in_op,
  input  wire logic [dqra_pkg::INDEX_W-1:0]   in_index,
  input  wire logic [dqra_pkg::VALUE_W-1:0]   in_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [dqra_pkg::VALUE_W-1:0]   out_read_value,
  output logic      [dqra_pkg::LENGTH_W-1:0]  out_length,
  output logic      [dqra_pkg::STATUS_W-1:0]  out_status
);
  import dqra_pkg::*;

  dqra_cmd_t cmd;

  dqra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  dqra_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

// ===== tb/sv/dqra_result_checker.sv =====
// Result checker for the deque with random access: predicts each result and compares it.
`timescale 1ns / 100ps

module dqra_result_checker
  import dqra_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [INDEX_W-1:0]    in_index,
  input  wire logic [VALUE_W-1:0]    in_value,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [VALUE_W-1:0]    out_read_value,
  input  wire logic [LENGTH_W-1:0]   out_length,
  input  wire logic [STATUS_W-1:0]   out_status,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);

  typedef struct packed {
    value_t  read_value;
    length_t length;
    status_t status;
  } deque_result_t;

  localparam int unsigned CAPACITY = DEF_DEPTH;

  // Mirror of the deque: store, head slot and live length
  value_t        shadow_store [CAPACITY];
  logic [7:0]    head_slot;
  length_t       live_len;
  deque_result_t expected_results [$];
  int            errors;
  int            matched;

  initial begin
    errors     = 0;
    matched    = 0;
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    head_slot  = '0;
    live_len   = '0;
  end

  // Apply one request to the mirror and return its result.
  // Slot arithmetic wraps at 8 bits, which matches a store of 256 words.
  function automatic deque_result_t deque_apply(input op_t op, input index_t idx,
                                                input value_t val);
    deque_result_t r;
    logic [7:0]    slot;
    r.read_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_GET, OP_SET: begin
        if ({1'b0, idx} >= live_len) begin
          r.status = ST_RANGE;
        end else begin
          slot = head_slot + idx;
          if (op == OP_GET) r.read_value = shadow_store[slot];
          else shadow_store[slot] = val;
        end
      end
      OP_PUSH_TAIL: begin
        if (live_len == CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_store[head_slot + live_len[7:0]] = val;
          live_len = live_len + 1'b1;
        end
      end
      OP_POP_TAIL: begin
        if (live_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          live_len = live_len - 1'b1;
          r.read_value = shadow_store[head_slot + live_len[7:0]];
        end
      end
      OP_PUSH_HEAD: begin
        if (live_len == CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          head_slot = head_slot - 1'b1;
          shadow_store[head_slot] = val;
          live_len = live_len + 1'b1;
        end
      end
      OP_POP_HEAD: begin
        if (live_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = shadow_store[head_slot];
          head_slot = head_slot + 1'b1;
          live_len = live_len - 1'b1;
        end
      end
      default: ;  // length and the unused code leave the deque alone
    endcase
    r.length = live_len;
    return r;
  endfunction

  // Print one line per mismatch (capped) and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 40)
      $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
               $time, matched, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      head_slot = '0;
      live_len  = '0;
      expected_results.delete();
    end else begin
      // Predict each accepted request item
      if (in_valid && !in_stall)
        expected_results.push_back(deque_apply(op_t'(in_op), in_index, in_value));

      // Compare each accepted result item with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_read_value !== want.read_value)
            report_mismatch("read_value", out_read_value, want.read_value);
          if (out_length !== want.length)
            report_mismatch("length", out_length, want.length);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
        end
        matched++;
      end
    end
    fail_count <= errors;
    pending    <= expected_results.size();
    checked    <= matched;
  end

endmodule

// ===== tb/sv/tb_deque_with_random_access_unit.sv =====
// Testbench top for the deque with random access: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_deque_with_random_access_unit;
  import dqra_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int CAPACITY     = DEF_DEPTH;

  typedef enum logic [1:0] {
    MODE_GROW,
    MODE_MIX,
    MODE_DRAIN
  } fill_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_op = '0;
  index_t              in_index = '0;
  value_t              in_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  value_t              out_read_value;
  length_t             out_length;
  logic [STATUS_W-1:0] out_status;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int sent = 0;
  int fill_level = 0;
  int full_hits = 0;
  int empty_hits = 0;
  bit quiet = 1'b0;

  deque_with_random_access_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .out_status     (out_status)
  );

  dqra_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .out_status     (out_status),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked)
  );

  always #1 clk = ~clk;

  // Stall the result side at random, except during the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 19);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Present one item, with random idle cycles before it, and hold it until taken
  task automatic send_item(input op_t op, input index_t idx, input value_t val);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_index <= idx;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    // Track the fill level to steer the random mix
    case (op)
      OP_PUSH_TAIL, OP_PUSH_HEAD: begin
        if (fill_level == CAPACITY) full_hits++;
        else fill_level++;
      end
      OP_POP_TAIL, OP_POP_HEAD: begin
        if (fill_level == 0) empty_hits++;
        else fill_level--;
      end
      default: ;
    endcase
  endtask

  function automatic value_t pick_value();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Index mostly inside the live range, sometimes anywhere
  function automatic index_t pick_index();
    if (fill_level > 0 && $urandom_range(99) < 85)
      return index_t'($urandom_range(fill_level - 1));
    return index_t'($urandom_range(255));
  endfunction

  // Choose an operation for the current fill mode
  function automatic op_t pick_op(input fill_mode_e mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_GROW: begin
        if (roll < 40) return OP_PUSH_TAIL;
        if (roll < 80) return OP_PUSH_HEAD;
        if (roll < 85) return OP_GET;
        if (roll < 89) return OP_SET;
        if (roll < 92) return OP_POP_TAIL;
        if (roll < 94) return OP_POP_HEAD;
        if (roll < 98) return OP_LENGTH;
        return OP_UNUSED;
      end
      MODE_DRAIN: begin
        if (roll < 40) return OP_POP_TAIL;
        if (roll < 80) return OP_POP_HEAD;
        if (roll < 85) return OP_GET;
        if (roll < 89) return OP_SET;
        if (roll < 92) return OP_PUSH_TAIL;
        if (roll < 94) return OP_PUSH_HEAD;
        if (roll < 98) return OP_LENGTH;
        return OP_UNUSED;
      end
      default: begin
        if (roll < 30) return OP_GET;
        if (roll < 50) return OP_SET;
        if (roll < 62) return OP_PUSH_TAIL;
        if (roll < 74) return OP_PUSH_HEAD;
        if (roll < 84) return OP_POP_TAIL;
        if (roll < 94) return OP_POP_HEAD;
        if (roll < 98) return OP_LENGTH;
        return OP_UNUSED;
      end
    endcase
  endfunction

  initial begin
    fill_mode_e mode;
    int         edge_tries;
    int         mix_left;
    op_t        op;

    // Hold reset, then release it
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-deque errors, unused code, wrap of the head, edges of fields
    send_item(OP_LENGTH,    8'd0,   32'h0);
    send_item(OP_POP_TAIL,  8'd0,   32'h0);
    send_item(OP_POP_HEAD,  8'd0,   32'h0);
    send_item(OP_GET,       8'd0,   32'h0);
    send_item(OP_SET,       8'd255, 32'hFFFF_FFFF);
    send_item(OP_UNUSED,    8'd255, 32'hFFFF_FFFF);
    send_item(OP_PUSH_TAIL, 8'd0,   32'hFFFF_FFFF);
    send_item(OP_PUSH_HEAD, 8'd0,   32'h0000_0000);
    send_item(OP_PUSH_TAIL, 8'd0,   32'h5A5A_5A5A);
    send_item(OP_GET,       8'd0,   32'h0);
    send_item(OP_GET,       8'd2,   32'h0);
    send_item(OP_GET,       8'd3,   32'h0);
    send_item(OP_SET,       8'd1,   32'hA5A5_A5A5);
    send_item(OP_GET,       8'd1,   32'h0);
    send_item(OP_SET,       8'd3,   32'h1234_5678);
    send_item(OP_LENGTH,    8'd255, 32'hFFFF_FFFF);
    send_item(OP_POP_HEAD,  8'd0,   32'h0);
    send_item(OP_POP_TAIL,  8'd0,   32'h0);
    send_item(OP_POP_TAIL,  8'd0,   32'h0);
    send_item(OP_POP_HEAD,  8'd0,   32'h0);
    send_item(OP_UNUSED,    8'd0,   32'h0);
    send_item(OP_PUSH_HEAD, 8'd128, 32'h8000_0001);
    send_item(OP_GET,       8'd0,   32'h0);
    send_item(OP_POP_TAIL,  8'd0,   32'h0);

    // Random: fill to capacity, mix, drain to empty, and repeat
    mode       = MODE_GROW;
    edge_tries = 0;
    mix_left   = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 150 && n < 300);
      op = pick_op(mode);
      send_item(op, pick_index(), pick_value());
      case (mode)
        MODE_GROW: begin
          if (fill_level == CAPACITY) edge_tries++;
          if (edge_tries >= 6) begin
            mode       = MODE_MIX;
            mix_left   = 60;
            edge_tries = 0;
          end
        end
        MODE_DRAIN: begin
          if (fill_level == 0) edge_tries++;
          if (edge_tries >= 6) begin
            mode       = MODE_MIX;
            mix_left   = 40;
            edge_tries = 0;
          end
        end
        default: begin
          mix_left--;
          if (mix_left <= 0) mode = (fill_level > CAPACITY / 2) ? MODE_DRAIN : MODE_GROW;
        end
      endcase
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain outstanding results, then allow for stray late ones
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d request items and checked %0d results in %0d cycles.",
             sent, checked, cycles);
    $display("Pushes refused at capacity: %0d; pops refused when empty: %0d.",
             full_hits, empty_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== deque_with_random_access_unit.f =====
rtl/dqra_pkg.sv
rtl/dqra_dp.sv
rtl/dqra_ctrl.sv
rtl/deque_with_random_access_unit.sv
tb/sv/dqra_result_checker.sv
tb/sv/tb_deque_with_random_access_unit.sv
